// ===== sv/zsvr_pkg.sv =====
// Shared types, code tables and helpers for the sequence value resolver.
`default_nettype none

package zsvr_pkg;

  // Code table sizes and the repeat-offset range
  localparam int LL_CODE_COUNT = 36;
  localparam int ML_CODE_COUNT = 53;
  localparam int OF_CODE_MAX   = 31;
  localparam int REPEAT_COUNT  = 3;

  // Field widths
  localparam int CODE_W      = 8;
  localparam int LEN_EXTRA_W = 16;
  localparam int OF_EXTRA_W  = 31;
  localparam int LIT_LEN_W   = 17;
  localparam int MATCH_LEN_W = 18;
  localparam int DIST_W      = 32;
  localparam int WINDOW_W    = 31;
  localparam int BITS_W      = 5;
  localparam int TBL_IDX_W   = 6;

  // Stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_OFFSET_CODE = 3'd1,
    ERR_MATCH_CODE  = 3'd2,
    ERR_LIT_CODE    = 3'd3,
    ERR_REPEAT      = 3'd4,
    ERR_HISTORY     = 3'd5
  } err_t;

  // Literal length baselines and extra-bit counts
  localparam logic [LIT_LEN_W-1:0] LL_BASE [LL_CODE_COUNT] = '{
    17'd0, 17'd1, 17'd2, 17'd3, 17'd4, 17'd5, 17'd6, 17'd7, 17'd8, 17'd9,
    17'd10, 17'd11, 17'd12, 17'd13, 17'd14, 17'd15, 17'd16, 17'd18, 17'd20,
    17'd22, 17'd24, 17'd28, 17'd32, 17'd40, 17'd48, 17'd64, 17'd128, 17'd256,
    17'd512, 17'd1024, 17'd2048, 17'd4096, 17'd8192, 17'd16384, 17'd32768,
    17'd65536};
  localparam logic [BITS_W-1:0] LL_BITS [LL_CODE_COUNT] = '{
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd1, 5'd1, 5'd1, 5'd2, 5'd2, 5'd3, 5'd3,
    5'd4, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15,
    5'd16};

  // Match length baselines and extra-bit counts
  localparam logic [LIT_LEN_W-1:0] ML_BASE [ML_CODE_COUNT] = '{
    17'd3, 17'd4, 17'd5, 17'd6, 17'd7, 17'd8, 17'd9, 17'd10, 17'd11, 17'd12,
    17'd13, 17'd14, 17'd15, 17'd16, 17'd17, 17'd18, 17'd19, 17'd20, 17'd21,
    17'd22, 17'd23, 17'd24, 17'd25, 17'd26, 17'd27, 17'd28, 17'd29, 17'd30,
    17'd31, 17'd32, 17'd33, 17'd34, 17'd35, 17'd37, 17'd39, 17'd41, 17'd43,
    17'd47, 17'd51, 17'd59, 17'd67, 17'd83, 17'd99, 17'd131, 17'd259, 17'd515,
    17'd1027, 17'd2051, 17'd4099, 17'd8195, 17'd16387, 17'd32771, 17'd65539};
  localparam logic [BITS_W-1:0] ML_BITS [ML_CODE_COUNT] = '{
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
    5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd1, 5'd1, 5'd1,
    5'd2, 5'd2, 5'd3, 5'd3, 5'd4, 5'd4, 5'd5, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11,
    5'd12, 5'd13, 5'd14, 5'd15, 5'd16};

  // Decoded sequence held in the input register
  typedef struct packed {
    logic                   first;
    logic [LIT_LEN_W-1:0]   lit_len;
    logic [MATCH_LEN_W-1:0] match_len;
    logic [DIST_W-1:0]      of_value;
    err_t                   err;
  } dec_item_t;

  // Resolved result held in the output register
  typedef struct packed {
    err_t                   error_code;
    logic [DIST_W-1:0]      match_distance;
    logic [MATCH_LEN_W-1:0] match_bytes;
    logic [LIT_LEN_W-1:0]   lit_bytes;
  } result_t;

  // Keep the low bits of a length extra value
  function automatic logic [LEN_EXTRA_W-1:0] len_mask(input logic [BITS_W-1:0] bits);
    logic [LEN_EXTRA_W:0] full;
    full = ((LEN_EXTRA_W+1)'(1) << bits) - (LEN_EXTRA_W+1)'(1);
    return full[LEN_EXTRA_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/zstd_sequence_value_resolver_unit.sv =====
// Top level: input register, resolve stage and output register of the resolver.
//
//  channel   dir  signals                       moves
//  s_*       in   s_tvalid s_tready s_tdata      one decoded sequence (codes + extra bits)
//  m_*       out  m_tvalid m_tready m_tdata      lengths, distance and error code
//  cfg_*     in   cfg_wr_en cfg_wr_data          history window size
//
//  One item per cycle while m_tready is high; m_tvalid comes from the input register.
//  The rate is set by the repeat-slot and position update, committed with the result.
//  Lengths and the offset value are decoded ahead of the input register.
//  rst clears both stage valids, the window to 0 and the slots to 1, 4, 8.
//  m_tready low holds the result; the input register still takes an item if empty.
`default_nettype none

module zstd_sequence_value_resolver_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [zsvr_pkg::WINDOW_W-1:0]        cfg_wr_data,
  input  wire logic                                 s_tvalid,
  output      logic                                 s_tready,
  // [0] first_of_block, [8:1] lit_len_code, [16:9] match_len_code,
  // [24:17] offset_code, [40:25] lit_len_extra, [56:41] match_len_extra,
  // [87:57] offset_extra
  input  wire logic [zsvr_pkg::IN_TDATA_W-1:0]      s_tdata,
  output      logic                                 m_tvalid,
  input  wire logic                                 m_tready,
  // [16:0] literal length, [34:17] match length, [66:35] match_distance,
  // [69:67] error_code, [71:70] zero
  output      logic [zsvr_pkg::OUT_TDATA_W-1:0]     m_tdata
);
  import zsvr_pkg::*;

  logic [WINDOW_W-1:0] window;
  dec_item_t           dec;
  dec_item_t           item;
  logic                item_valid;
  result_t             res;
  result_t             result;
  logic                advance;

  // Hold the history window
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (cfg_wr_en) begin
      window <= cfg_wr_data;
    end
  end

  // Decode codes into lengths and the offset value
  zsvr_len_decode u_decode (
    .first_of_block  (s_tdata[0]),
    .lit_len_code    (s_tdata[8:1]),
    .match_len_code  (s_tdata[16:9]),
    .offset_code     (s_tdata[24:17]),
    .lit_len_extra   (s_tdata[40:25]),
    .match_len_extra (s_tdata[56:41]),
    .offset_extra    (s_tdata[87:57]),
    .item            (dec)
  );

  // Stage handshake
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !item_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= dec;
    end
  end

  // Resolve against the repeat slots and output position
  zsvr_resolve u_resolve (
    .clk    (clk),
    .rst    (rst),
    .step   (item_valid && advance),
    .window (window),
    .item   (item),
    .res    (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      result <= res;
    end
  end

  assign m_tdata = {2'b00, result};

  // An error result carries no lengths and no distance
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[69:67] != ERR_NONE |-> m_tdata[66:0] == '0)
    else $error("error result with nonzero payload");

  // A clean result never points at distance zero
  a_dist_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[69:67] == ERR_NONE |-> m_tdata[66:35] != '0)
    else $error("clean result with zero distance");

  // An empty output register never stalls the input side
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with output register empty");

  // An item in the input register reaches the output the next cycle it may move
  a_item_moves: assert property (@(posedge clk) disable iff (rst)
    item_valid && advance |=> m_tvalid)
    else $error("item lost between stages");

endmodule

`default_nettype wire

// ===== sv/zsvr_len_decode.sv =====
// Code checks, length table lookups and offset value forming for one sequence.
`default_nettype none

module zsvr_len_decode (
  input  wire logic                               first_of_block,
  input  wire logic [zsvr_pkg::CODE_W-1:0]        lit_len_code,
  input  wire logic [zsvr_pkg::CODE_W-1:0]        match_len_code,
  input  wire logic [zsvr_pkg::CODE_W-1:0]        offset_code,
  input  wire logic [zsvr_pkg::LEN_EXTRA_W-1:0]   lit_len_extra,
  input  wire logic [zsvr_pkg::LEN_EXTRA_W-1:0]   match_len_extra,
  input  wire logic [zsvr_pkg::OF_EXTRA_W-1:0]    offset_extra,
  output zsvr_pkg::dec_item_t                     item
);
  import zsvr_pkg::*;

  logic                  of_bad;
  logic                  ml_bad;
  logic                  ll_bad;
  logic [TBL_IDX_W-1:0]  ll_idx;
  logic [TBL_IDX_W-1:0]  ml_idx;
  logic [4:0]            of_shift;
  logic [OF_EXTRA_W:0]   of_mask_full;
  logic [OF_EXTRA_W-1:0] of_extra_kept;

  // Range-check the three codes
  assign of_bad = offset_code > CODE_W'(OF_CODE_MAX);
  assign ml_bad = match_len_code >= CODE_W'(ML_CODE_COUNT);
  assign ll_bad = lit_len_code >= CODE_W'(LL_CODE_COUNT);

  // Park the table index on entry zero for a code out of range
  assign ll_idx = ll_bad ? '0 : lit_len_code[TBL_IDX_W-1:0];
  assign ml_idx = ml_bad ? '0 : match_len_code[TBL_IDX_W-1:0];

  // Offset value: 2^code plus the code's count of extra bits
  assign of_shift      = offset_code[4:0];
  assign of_mask_full  = ((OF_EXTRA_W+1)'(1) << of_shift) - (OF_EXTRA_W+1)'(1);
  assign of_extra_kept = offset_extra & of_mask_full[OF_EXTRA_W-1:0];

  always_comb begin
    item.first     = first_of_block;
    item.lit_len   = LL_BASE[ll_idx] + LIT_LEN_W'(lit_len_extra & len_mask(LL_BITS[ll_idx]));
    item.match_len = MATCH_LEN_W'(ML_BASE[ml_idx])
                   + MATCH_LEN_W'(match_len_extra & len_mask(ML_BITS[ml_idx]));
    item.of_value  = (DIST_W'(1) << of_shift) + DIST_W'(of_extra_kept);
    priority if (of_bad) begin
      item.err = ERR_OFFSET_CODE;
    end else if (ml_bad) begin
      item.err = ERR_MATCH_CODE;
    end else if (ll_bad) begin
      item.err = ERR_LIT_CODE;
    end else begin
      item.err = ERR_NONE;
    end
  end

endmodule

`default_nettype wire

// ===== sv/zsvr_resolve.sv =====
// Repeat-offset resolution, history check and the slot and position state.
`default_nettype none

module zsvr_resolve (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            step,
  input  wire logic [zsvr_pkg::WINDOW_W-1:0]   window,
  input  wire zsvr_pkg::dec_item_t             item,
  output zsvr_pkg::result_t                    res
);
  import zsvr_pkg::*;

  logic [DIST_W-1:0]   slot_one;
  logic [DIST_W-1:0]   slot_two;
  logic [DIST_W-1:0]   slot_three;
  logic [DIST_W-1:0]   position;
  logic [DIST_W-1:0]   slot_one_next;
  logic [DIST_W-1:0]   slot_two_next;
  logic [DIST_W-1:0]   slot_three_next;
  logic [DIST_W-1:0]   position_next;

  logic [DIST_W-1:0]   back_dist;
  logic                rep_err;
  logic [1:0]          sel;
  logic [DIST_W-1:0]   pos_base;
  logic [DIST_W:0]     pos_lit;
  logic [DIST_W+1:0]   reach;
  logic [DIST_W+1:0]   pos_end;
  logic                too_far;
  err_t                err;

  // Pick the distance and reorder the repeat slots
  always_comb begin
    back_dist       = '0;
    rep_err         = 1'b0;
    slot_one_next   = slot_one;
    slot_two_next   = slot_two;
    slot_three_next = slot_three;
    sel             = item.of_value[1:0] - 2'd1 + {1'b0, item.lit_len == '0};
    if (item.of_value > DIST_W'(REPEAT_COUNT)) begin
      back_dist       = item.of_value - DIST_W'(REPEAT_COUNT);
      slot_three_next = slot_two;
      slot_two_next   = slot_one;
      slot_one_next   = back_dist;
    end else begin
      unique case (sel)
        2'd0: begin
          back_dist = slot_one;
        end
        2'd1: begin
          back_dist     = slot_two;
          slot_two_next = slot_one;
          slot_one_next = slot_two;
        end
        2'd2: begin
          back_dist       = slot_three;
          slot_three_next = slot_two;
          slot_two_next   = slot_one;
          slot_one_next   = slot_three;
        end
        default: begin
          rep_err         = slot_one <= DIST_W'(1);
          back_dist       = slot_one - DIST_W'(1);
          slot_three_next = slot_two;
          slot_two_next   = slot_one;
          slot_one_next   = back_dist;
        end
      endcase
    end
  end

  // Advance the output position and check reach into history
  always_comb begin
    pos_base      = item.first ? '0 : position;
    pos_lit       = {1'b0, pos_base} + (DIST_W+1)'(item.lit_len);
    reach         = (DIST_W+2)'(window) + {1'b0, pos_lit};
    too_far       = {2'b00, back_dist} > reach;
    pos_end       = {1'b0, pos_lit} + (DIST_W+2)'(item.match_len);
    position_next = (pos_end[DIST_W+1:DIST_W] != 2'b00) ? '1 : pos_end[DIST_W-1:0];
  end

  // Rank the errors and form the result
  always_comb begin
    priority if (item.err != ERR_NONE) begin
      err = item.err;
    end else if (rep_err) begin
      err = ERR_REPEAT;
    end else if (back_dist == '0 || too_far) begin
      err = ERR_HISTORY;
    end else begin
      err = ERR_NONE;
    end
    res.error_code = err;
    if (err == ERR_NONE) begin
      res.lit_bytes      = item.lit_len;
      res.match_bytes    = item.match_len;
      res.match_distance = back_dist;
    end else begin
      res.lit_bytes      = '0;
      res.match_bytes    = '0;
      res.match_distance = '0;
    end
  end

  // Commit slots and position only for a clean item
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_one   <= DIST_W'(1);
      slot_two   <= DIST_W'(4);
      slot_three <= DIST_W'(8);
      position   <= '0;
    end else if (step && err == ERR_NONE) begin
      slot_one   <= slot_one_next;
      slot_two   <= slot_two_next;
      slot_three <= slot_three_next;
      position   <= position_next;
    end
  end

endmodule

`default_nettype wire

// ===== sim/zsvr_result_checker.sv =====
// Checker for the sequence value resolver: predicts each result and compares it on the output.
`timescale 1ns / 1ps

module zsvr_result_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [zsvr_pkg::WINDOW_W-1:0]    cfg_wr_data,
  input  wire logic                             s_tvalid,
  input  wire logic                             s_tready,
  // [0] first_of_block, [8:1] lit_len_code, [16:9] match_len_code,
  // [24:17] offset_code, [40:25] lit_len_extra, [56:41] match_len_extra,
  // [87:57] offset_extra
  input  wire logic [zsvr_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  wire logic                             m_tvalid,
  input  wire logic                             m_tready,
  // [16:0] literal length, [34:17] match length, [66:35] match_distance,
  // [69:67] error_code, [71:70] zero
  input  wire logic [zsvr_pkg::OUT_TDATA_W-1:0] m_tdata,
  output int                                    results_awaited,
  output int                                    mismatch_count
);
  import zsvr_pkg::*;

  // Predicted copy of the block state
  logic [WINDOW_W-1:0] window_bytes;
  logic [31:0]         slot1;
  logic [31:0]         slot2;
  logic [31:0]         slot3;
  logic [31:0]         out_pos;

  result_t pending_resolutions[$];
  result_t want;
  int      fails;

  initial begin
    fails = 0;
  end

  // Resolve one sequence against the predicted state; commit the state only on success
  function automatic result_t resolve_sequence(input logic [IN_TDATA_W-1:0] d);
    logic        first;
    logic [7:0]  llc;
    logic [7:0]  mlc;
    logic [7:0]  ofc;
    logic [63:0] lle;
    logic [63:0] mle;
    logic [63:0] ofe;
    logic [63:0] value;
    logic [63:0] lit;
    logic [63:0] mlen;
    logic [63:0] back_dist;
    logic [63:0] pos;
    logic [63:0] hist;
    logic [63:0] npos;
    logic [31:0] r1;
    logic [31:0] r2;
    logic [31:0] r3;
    int          sel;
    result_t     res;
    first = d[0];
    llc   = d[8:1];
    mlc   = d[16:9];
    ofc   = d[24:17];
    lle   = 64'(d[40:25]);
    mle   = 64'(d[56:41]);
    ofe   = 64'(d[87:57]);
    r1    = slot1;
    r2    = slot2;
    r3    = slot3;
    res   = '0;
    res.error_code = ERR_NONE;

    // Reject bad codes, offset first, then match, then literal
    if (ofc > OF_CODE_MAX) begin
      res.error_code = ERR_OFFSET_CODE;
      return res;
    end
    if (mlc >= ML_CODE_COUNT) begin
      res.error_code = ERR_MATCH_CODE;
      return res;
    end
    if (llc >= LL_CODE_COUNT) begin
      res.error_code = ERR_LIT_CODE;
      return res;
    end

    // Baseline plus extra bits, the extra cut to the code's bit count
    if (ofc == 0)
      value = 64'd1;
    else
      value = (64'd1 << ofc) + (ofe & ((64'd1 << ofc) - 64'd1));
    mlen = 64'(ML_BASE[mlc]) + (mle & ((64'd1 << ML_BITS[mlc]) - 64'd1));
    lit  = 64'(LL_BASE[llc]) + (lle & ((64'd1 << LL_BITS[llc]) - 64'd1));

    // New distance or repeat slot, shifted by one when there are no literals
    if (value > REPEAT_COUNT) begin
      back_dist = value - REPEAT_COUNT;
      r3 = r2;
      r2 = r1;
      r1 = back_dist[31:0];
    end else begin
      sel = int'(value[1:0]) - 1 + int'(lit == 64'd0);
      case (sel)
        0: back_dist = 64'(r1);
        1: begin
          back_dist = 64'(r2);
          r2 = r1;
          r1 = back_dist[31:0];
        end
        2: begin
          back_dist = 64'(r3);
          r3 = r2;
          r2 = r1;
          r1 = back_dist[31:0];
        end
        default: begin
          if (r1 <= 32'd1) begin
            res.error_code = ERR_REPEAT;
            return res;
          end
          back_dist = 64'(r1) - 64'd1;
          r3 = r2;
          r2 = r1;
          r1 = back_dist[31:0];
        end
      endcase
    end

    // Check the reach against the window plus the output so far
    pos  = first ? 64'd0 : 64'(out_pos);
    pos  = pos + lit;
    hist = 64'(window_bytes) + pos;
    if (back_dist == 64'd0 || back_dist > hist) begin
      res.error_code = ERR_HISTORY;
      return res;
    end

    // Advance the position, saturating at the top of 32 bits
    npos = pos + mlen;
    if (npos > 64'hFFFF_FFFF)
      npos = 64'hFFFF_FFFF;
    slot1   = r1;
    slot2   = r2;
    slot3   = r3;
    out_pos = npos[31:0];
    res.lit_bytes      = lit[LIT_LEN_W-1:0];
    res.match_bytes    = mlen[MATCH_LEN_W-1:0];
    res.match_distance = back_dist[DIST_W-1:0];
    return res;
  endfunction

  // Report one field that differs from the prediction
  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
    end
  endfunction

  // Track config writes, predict on each input item, compare each output item
  always @(posedge clk) begin
    if (rst) begin
      window_bytes = '0;
      slot1        = 32'd1;
      slot2        = 32'd4;
      slot3        = 32'd8;
      out_pos      = 32'd0;
      pending_resolutions.delete();
    end else begin
      if (cfg_wr_en)
        window_bytes = cfg_wr_data;
      if (s_tvalid && s_tready)
        pending_resolutions.push_back(resolve_sequence(s_tdata));
      if (m_tvalid && m_tready) begin
        if (pending_resolutions.size() == 0) begin
          fails++;
          $display("%0t: result with nothing pending, expected none, actual %h",
                   $time, m_tdata);
        end else begin
          want = pending_resolutions.pop_front();
          check_field("lit_bytes", 32'(want.lit_bytes), 32'(m_tdata[16:0]));
          check_field("match_bytes", 32'(want.match_bytes), 32'(m_tdata[34:17]));
          check_field("match_distance", want.match_distance, m_tdata[66:35]);
          check_field("error_code", 32'(want.error_code), 32'(m_tdata[69:67]));
        end
      end
    end
    results_awaited <= pending_resolutions.size();
    mismatch_count  <= fails;
  end

endmodule

// ===== sim/tb_zstd_sequence_value_resolver_unit.sv =====
// Testbench top for the sequence value resolver: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module tb_zstd_sequence_value_resolver_unit;
  import zsvr_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 155;
  localparam int FILL_ITEMS     = 16;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   cfg_wr_en   = 1'b0;
  logic [WINDOW_W-1:0]    cfg_wr_data = '0;
  logic                   s_tvalid    = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata     = '0;
  logic                   m_tvalid;
  logic                   m_tready    = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int results_awaited;
  int mismatch_count;
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  int rx_hold      = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  zstd_sequence_value_resolver_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  zsvr_result_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .results_awaited(results_awaited),
    .mismatch_count (mismatch_count)
  );

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold  <= rx_hold - 1;
    end else begin
      m_tready <= 1'b1;
      if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct)
        rx_hold <= $urandom_range(1, 7);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one sequence, maybe after an idle burst, and hold it until taken
  task automatic send_seq(input logic first, input logic [7:0] llc, input logic [7:0] mlc,
                          input logic [7:0] ofc, input logic [15:0] lle,
                          input logic [15:0] mle, input logic [30:0] ofe);
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ofe, mle, lle, ofc, mlc, llc, first};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Build a random sequence: mostly valid codes, a few broken ones
  task automatic send_random_seq();
    logic        first;
    logic [7:0]  llc;
    logic [7:0]  mlc;
    logic [7:0]  ofc;
    logic [15:0] lle;
    logic [15:0] mle;
    logic [30:0] ofe;
    first = ($urandom_range(0, 19) == 0);
    lle   = 16'($urandom());
    mle   = 16'($urandom());
    ofe   = 31'($urandom());
    llc   = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(0, LL_CODE_COUNT - 1));
    mlc   = 8'($urandom_range(0, ML_CODE_COUNT - 1));
    case ($urandom_range(0, 9))
      0, 1:    ofc = 8'd0;
      2, 3:    ofc = 8'd1;
      4:       ofc = 8'($urandom_range(2, OF_CODE_MAX));
      default: ofc = 8'($urandom_range(2, 14));
    endcase
    // Break one code in a few items, with the others left random
    if ($urandom_range(0, 99) < 6) begin
      case ($urandom_range(0, 2))
        0: begin
          ofc = 8'($urandom_range(OF_CODE_MAX + 1, 255));
          mlc = 8'($urandom());
          llc = 8'($urandom());
        end
        1: begin
          mlc = 8'($urandom_range(ML_CODE_COUNT, 255));
          llc = 8'($urandom());
        end
        default: llc = 8'($urandom_range(LL_CODE_COUNT, 255));
      endcase
    end
    send_seq(first, llc, mlc, ofc, lle, mle, ofe);
  endtask

  // Hold the sender until every pending result has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_awaited != 0);
  endtask

  // Write the history window while the block is idle
  task automatic set_window(input logic [WINDOW_W-1:0] bytes);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= bytes;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Pick an idling mix for both sides: none, light or heavy
  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  logic [WINDOW_W-1:0] phase_window [8];

  initial begin
    phase_window[0] = '0;
    phase_window[1] = 31'h7FFF_FFFF;
    phase_window[2] = 31'd16;
    phase_window[3] = 31'd4096;
    phase_window[4] = 31'($urandom());
    phase_window[5] = 31'd1 << 20;
    phase_window[6] = 31'h7FFF_FFFF;
    phase_window[7] = 31'($urandom_range(0, 65535));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed sequences with the window at its reset value of zero
    tx_gap_pct    = 20;
    rx_stall_pct <= 20;
    send_seq(1'b1, 8'd0, 8'd0, 8'd0, 16'h0, 16'h0, 31'h0);          // shifted slot beyond history
    send_seq(1'b0, 8'd35, 8'd52, 8'd0, 16'hFFFF, 16'hFFFF, 31'h0);  // longest lengths
    send_seq(1'b0, 8'd255, 8'd255, 8'd255, 16'h0, 16'h0, 31'h0);    // all codes bad
    send_seq(1'b0, 8'd255, 8'd255, 8'd31, 16'h0, 16'h0, 31'h0);     // match and literal bad
    send_seq(1'b0, 8'd36, 8'd52, 8'd31, 16'h0, 16'h0, 31'h0);       // literal code bad
    send_seq(1'b0, 8'd0, 8'd0, 8'd1, 16'h0, 16'h0, 31'h1);          // slot one minus one underflows
    send_seq(1'b0, 8'd5, 8'd3, 8'd1, 16'h0, 16'h0, 31'h0);          // repeat slot two
    send_seq(1'b0, 8'd5, 8'd3, 8'd1, 16'h0, 16'h0, 31'h1);          // repeat slot three
    send_seq(1'b0, 8'd0, 8'd3, 8'd1, 16'h0, 16'h0, 31'h0);          // no literals, slot three
    send_seq(1'b0, 8'd1, 8'd0, 8'd0, 16'h0, 16'h0, 31'h0);          // repeat slot one
    send_seq(1'b0, 8'd2, 8'd0, 8'd5, 16'h0, 16'h0, 31'h7FFF_FFFF);  // offset extra too wide
    send_seq(1'b0, 8'd0, 8'd0, 8'd1, 16'h0, 16'h0, 31'h1);          // slot one minus one
    send_seq(1'b0, 8'd16, 8'd32, 8'd0, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF); // length extras too wide
    send_seq(1'b1, 8'd0, 8'd0, 8'd2, 16'h0, 16'h0, 31'h0);          // error keeps the position
    send_seq(1'b0, 8'd0, 8'd0, 8'd2, 16'h0, 16'h0, 31'h0);
    send_seq(1'b0, 8'd3, 8'd0, 8'd31, 16'h0, 16'h0, 31'h7FFF_FFFF); // largest offset, no window
    send_seq(1'b1, 8'd24, 8'd40, 8'd3, 16'h00AB, 16'h1234, 31'h0);  // block start with literals

    // Directed sequences with the widest window
    set_window(31'h7FFF_FFFF);
    send_seq(1'b0, 8'd0, 8'd0, 8'd30, 16'h0, 16'h0, 31'h3FFF_FFFF);
    send_seq(1'b0, 8'd10, 8'd10, 8'd31, 16'h0, 16'h0, 31'h7FFF_FFFF);
    send_seq(1'b0, 8'd0, 8'd0, 8'd31, 16'h0, 16'h0, 31'h0);
    send_seq(1'b0, 8'd0, 8'd0, 8'd1, 16'h0, 16'h0, 31'h1);

    // Random phases across window settings and idling mixes
    for (int p = 0; p < 8; p++) begin
      set_window(phase_window[p]);
      tx_gap_pct    = pick_idle_pct();
      rx_stall_pct <= pick_idle_pct();
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_random_seq();
    end

    // Run the output position up with the longest lengths
    set_window(31'h7FFF_FFFF);
    tx_gap_pct    = 0;
    rx_stall_pct <= 0;
    send_seq(1'b1, 8'd35, 8'd52, 8'd2, 16'hFFFF, 16'hFFFF, 31'h0);
    for (int i = 0; i < FILL_ITEMS; i++)
      send_seq(1'b0, 8'd35, 8'd52, 8'd0, 16'hFFFF, 16'hFFFF, 31'h0);
    send_seq(1'b0, 8'd0, 8'd0, 8'd31, 16'h0, 16'h0, 31'h7FFF_FFFF);
    send_seq(1'b0, 8'd35, 8'd52, 8'd0, 16'hFFFF, 16'hFFFF, 31'h0);
    send_seq(1'b1, 8'd0, 8'd0, 8'd31, 16'h0, 16'h0, 31'h7FFF_FFFF);

    // Final phase with no idling on either side
    set_window(31'($urandom_range(0, 1 << 20)));
    send_seq(1'b1, 8'd20, 8'd10, 8'd0, 16'h3, 16'h0, 31'h0);
    for (int i = 0; i < 120; i++)
      send_random_seq();

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
